// ===== src/sga_pkg.sv =====
// ----------------------------------------------------------------------------
// sga_pkg
// Shared widths, register indexes and the body record passed from the
// front end to the back end of the softened gravity accumulator.
// ----------------------------------------------------------------------------
package sga_pkg;

   // fixed field widths
   localparam int DATA_W     = 32;
   localparam int ACC_OUT_W  = 48;
   localparam int MASS_OUT_W = 47;
   localparam int D2_W       = 64;
   localparam int CSR_IDX_W  = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Z     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTENING_SQ = 8'd3;

   // one classified body: offset magnitudes, signs and squared distance
   typedef struct packed {
      logic [DATA_W-1:0] mass;
      logic [DATA_W-1:0] abs_x;
      logic [DATA_W-1:0] abs_y;
      logic [DATA_W-1:0] abs_z;
      logic              neg_x;
      logic              neg_y;
      logic              neg_z;
      logic [D2_W-1:0]   d2;
      logic              last;
   } sga_body_type;

endpackage

// ===== src/sga_if.sv =====
// ----------------------------------------------------------------------------
// sga_req_if / sga_rsp_if
// Valid/ready channels carrying body items in and result items out.
// ----------------------------------------------------------------------------
interface sga_req_if import sga_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] body_mass;
   logic [DATA_W-1:0] body_x;
   logic [DATA_W-1:0] body_y;
   logic [DATA_W-1:0] body_z;
   logic              last_body;

   modport source (output valid, body_mass, body_x, body_y, body_z, last_body,
                   input ready);
   modport sink   (input valid, body_mass, body_x, body_y, body_z, last_body,
                   output ready);
endinterface

interface sga_rsp_if import sga_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACC_OUT_W-1:0]  accel_x;
   logic [ACC_OUT_W-1:0]  accel_y;
   logic [ACC_OUT_W-1:0]  accel_z;
   logic [ACC_OUT_W-1:0]  potential;
   logic [MASS_OUT_W-1:0] mass_total;

   modport source (output valid, accel_x, accel_y, accel_z, potential, mass_total,
                   input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, potential, mass_total,
                   output ready);
endinterface

// ===== src/softened_gravity_accumulator.sv =====
// ----------------------------------------------------------------------------
// softened_gravity_accumulator
// Direct-sum softened gravity of a body stream on one field point.
//
// Bodies enter on req_ch (valid/ready); the item marked last_body closes the
// list and one result item (three acceleration sums, potential, mass total)
// leaves on rsp_ch, after which the running sums start again from zero.
// The field point and softening are to be written on the csr_ port while
// idle; the block itself does not enforce this. A body passes the front end
// into a 2-entry queue. The back end takes a body, picks the root shift,
// runs 32 square-root steps, two 64-step divisions with one potential
// update between, at most a low and a high multiply and a sum per axis, and
// a mass update. A body at zero distance goes straight to the mass update;
// one with an unbounded m/d^2 skips the second division. The serial
// divider sets the sustained rate. Results wait in an output register;
// while rsp_ch stalls the back end holds its finished item and the front
// end fills the queue. Synchronous reset clears CSRs, valids and sums.
// ----------------------------------------------------------------------------
module softened_gravity_accumulator import sga_pkg::*; #(
   parameter int FRAC_BITS = 24,
   parameter int SUM_WIDTH = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   sga_req_if.sink              req_ch,
   sga_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   logic [DATA_W-1:0] target_x_ff, target_y_ff, target_z_ff, softening_sq_ff;
   logic              f_valid, f_ready, q_valid, q_ready;
   sga_body_type      f_body, q_body;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff     <= '0;
         target_y_ff     <= '0;
         target_z_ff     <= '0;
         softening_sq_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_X:     target_x_ff     <= csr_wdata;
            CSR_TARGET_Y:     target_y_ff     <= csr_wdata;
            CSR_TARGET_Z:     target_z_ff     <= csr_wdata;
            CSR_SOFTENING_SQ: softening_sq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sga_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .target_x     (target_x_ff),
      .target_y     (target_y_ff),
      .target_z     (target_z_ff),
      .softening_sq (softening_sq_ff),
      .body_valid   (f_valid),
      .body_ready   (f_ready),
      .body_out     (f_body)
   );

   sga_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_body   (f_body),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_body  (q_body)
   );

   sga_back #(.FRAC_BITS(FRAC_BITS), .SUM_WIDTH(SUM_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .body_valid (q_valid),
      .body_ready (q_ready),
      .body_in    (q_body),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== src/sga_front.sv =====
// ----------------------------------------------------------------------------
// sga_front
// Three-stage front end: offset from the field point, squares, and the
// softened squared distance. Stages move together when the queue has room.
// ----------------------------------------------------------------------------
module sga_front import sga_pkg::*; #(
   parameter int FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   sga_req_if.sink           req_ch,
   input  logic [DATA_W-1:0] target_x,
   input  logic [DATA_W-1:0] target_y,
   input  logic [DATA_W-1:0] target_z,
   input  logic [DATA_W-1:0] softening_sq,
   output logic              body_valid,
   input  logic              body_ready,
   output sga_body_type      body_out
);

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                advance;
   logic signed [32:0]  rx, ry, rz;
   logic [32:0]         abx, aby, abz;

   logic [DATA_W-1:0]   s1_mass_ff, s1_ax_ff, s1_ay_ff, s1_az_ff;
   logic                s1_nx_ff, s1_ny_ff, s1_nz_ff, s1_last_ff;
   logic [DATA_W-1:0]   s2_mass_ff, s2_ax_ff, s2_ay_ff, s2_az_ff;
   logic                s2_nx_ff, s2_ny_ff, s2_nz_ff, s2_last_ff;
   logic [D2_W-1:0]     s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   sga_body_type        s3_body_ff, s3_body_in;

   assign advance      = !s3_valid_ff || body_ready;
   assign req_ch.ready = advance;

   // offset from field point, as sign and magnitude
   always_comb begin
      rx  = $signed({req_ch.body_x[31], req_ch.body_x}) - $signed({target_x[31], target_x});
      ry  = $signed({req_ch.body_y[31], req_ch.body_y}) - $signed({target_y[31], target_y});
      rz  = $signed({req_ch.body_z[31], req_ch.body_z}) - $signed({target_z[31], target_z});
      abx = rx[32] ? 33'(-rx) : 33'(rx);
      aby = ry[32] ? 33'(-ry) : 33'(ry);
      abz = rz[32] ? 33'(-rz) : 33'(rz);
   end

   // softened squared distance from the registered squares
   always_comb begin
      s3_body_in       = '0;
      s3_body_in.mass  = s2_mass_ff;
      s3_body_in.abs_x = s2_ax_ff;
      s3_body_in.abs_y = s2_ay_ff;
      s3_body_in.abs_z = s2_az_ff;
      s3_body_in.neg_x = s2_nx_ff;
      s3_body_in.neg_y = s2_ny_ff;
      s3_body_in.neg_z = s2_nz_ff;
      s3_body_in.last  = s2_last_ff;
      s3_body_in.d2    = (s2_sqx_ff >> FRAC_BITS) + (s2_sqy_ff >> FRAC_BITS)
                       + (s2_sqz_ff >> FRAC_BITS) + D2_W'(softening_sq);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mass_ff <= req_ch.body_mass;
         s1_ax_ff   <= abx[31:0];
         s1_ay_ff   <= aby[31:0];
         s1_az_ff   <= abz[31:0];
         s1_nx_ff   <= rx[32];
         s1_ny_ff   <= ry[32];
         s1_nz_ff   <= rz[32];
         s1_last_ff <= req_ch.last_body;

         s2_mass_ff <= s1_mass_ff;
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_az_ff   <= s1_az_ff;
         s2_nx_ff   <= s1_nx_ff;
         s2_ny_ff   <= s1_ny_ff;
         s2_nz_ff   <= s1_nz_ff;
         s2_last_ff <= s1_last_ff;
         s2_sqx_ff  <= s1_ax_ff * s1_ax_ff;
         s2_sqy_ff  <= s1_ay_ff * s1_ay_ff;
         s2_sqz_ff  <= s1_az_ff * s1_az_ff;

         s3_body_ff <= s3_body_in;
      end
   end

   assign body_valid = s3_valid_ff;
   assign body_out   = s3_body_ff;

endmodule

// ===== src/sga_queue.sv =====
// ----------------------------------------------------------------------------
// sga_queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module sga_queue import sga_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  sga_body_type in_body,
   output logic         out_valid,
   input  logic         out_ready,
   output sga_body_type out_body
);

   sga_body_type entry_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_body  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_body;
   end

endmodule

// ===== src/sga_back.sv =====
// ----------------------------------------------------------------------------
// sga_back
// Sequential back end: bit-pair square root, shared restoring divider,
// split 32x32 multiplier and one saturating adder for all running sums.
// ----------------------------------------------------------------------------
module sga_back import sga_pkg::*; #(
   parameter int FRAC_BITS = 24,
   parameter int SUM_WIDTH = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         body_valid,
   output logic         body_ready,
   input  sga_body_type body_in,
   sga_rsp_if.source    rsp_ch
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SHIFT = 4'd1;
   localparam logic [3:0] ST_SQRT  = 4'd2;
   localparam logic [3:0] ST_DIVP  = 4'd3;
   localparam logic [3:0] ST_POT   = 4'd4;
   localparam logic [3:0] ST_DIVT  = 4'd5;
   localparam logic [3:0] ST_MLO   = 4'd6;
   localparam logic [3:0] ST_MHI   = 4'd7;
   localparam logic [3:0] ST_MSUM  = 4'd8;
   localparam logic [3:0] ST_MASS  = 4'd9;
   localparam logic [3:0] ST_EMIT  = 4'd10;

   localparam int MAX_S = FRAC_BITS - (FRAC_BITS % 2);
   localparam logic signed [65:0] SAT_HI = 66'((66'sd1 <<< (SUM_WIDTH - 1)) - 66'sd1);
   localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

   typedef logic signed [SUM_WIDTH-1:0] sum_type;

   logic [3:0]   state_ff;
   sga_body_type body_ff;
   logic [4:0]   sh_ff;
   logic [63:0]  sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [5:0]   cnt_ff;
   logic [63:0]  dv_num_ff, dv_den_ff, dv_quo_ff;
   logic [64:0]  dv_rem_ff;
   logic [63:0]  t_ff;
   logic         tinf_ff;
   logic [1:0]   axis_ff;
   logic [63:0]  pl_ff, ph_ff;
   sum_type      sum_x_ff, sum_y_ff, sum_z_ff, sum_pot_ff, sum_mass_ff;
   logic         rsp_valid_ff;
   logic [ACC_OUT_W-1:0]  out_x_ff, out_y_ff, out_z_ff, out_pot_ff;
   logic [MASS_OUT_W-1:0] out_mass_ff;

   // low output bits of a sum, sign extended when the sum is narrower
   function automatic logic [ACC_OUT_W-1:0] out_bits(input sum_type v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[ACC_OUT_W-1:0];
   endfunction

   // radicand shift search
   logic [4:0]  s_half;
   logic [5:0]  s_amt;
   always_comb begin
      s_half = 5'(MAX_S >> 1);
      s_amt  = 6'(FRAC_BITS - MAX_S);
      for (int k = MAX_S; k >= 0; k -= 2) begin
         if ((body_ff.d2 >> (62 - FRAC_BITS + k)) == 64'd0) begin
            s_half = 5'(k >> 1);
            s_amt  = 6'(FRAC_BITS - k);
         end
      end
   end

   // square root step
   logic [63:0] sq_trial, sq_rem_nx, sq_res_nx, root_dist;
   logic        sq_ge;
   always_comb begin
      sq_trial  = sq_res_ff + sq_bit_ff;
      sq_ge     = (sq_rem_ff >= sq_trial);
      sq_rem_nx = sq_ge ? sq_rem_ff - sq_trial : sq_rem_ff;
      sq_res_nx = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : sq_res_ff >> 1;
      root_dist = sq_res_nx << sh_ff;
   end

   // divider step
   logic [64:0] dv_sh, dv_rem_nx;
   logic [63:0] dv_quo_nx;
   logic        dv_ge;
   always_comb begin
      dv_sh     = {dv_rem_ff[63:0], dv_num_ff[63]};
      dv_ge     = (dv_sh >= {1'b0, dv_den_ff});
      dv_rem_nx = dv_ge ? dv_sh - {1'b0, dv_den_ff} : dv_sh;
      dv_quo_nx = {dv_quo_ff[62:0], dv_ge};
   end

   // current axis operands and shared multiplier
   logic [31:0] cur_abs, mul_op;
   logic        cur_neg;
   logic [63:0] mul_out;
   logic [95:0] prod;
   logic [63:0] axis_mag;
   always_comb begin
      case (axis_ff)
         2'd0:    begin cur_abs = body_ff.abs_x; cur_neg = body_ff.neg_x; end
         2'd1:    begin cur_abs = body_ff.abs_y; cur_neg = body_ff.neg_y; end
         default: begin cur_abs = body_ff.abs_z; cur_neg = body_ff.neg_z; end
      endcase
      mul_op   = (state_ff == ST_MLO) ? t_ff[31:0] : t_ff[63:32];
      mul_out  = mul_op * cur_abs;
      prod     = {ph_ff, 32'd0} + {32'd0, pl_ff};
      axis_mag = (prod[95:64] != 32'd0) ? '1 : prod[63:0] >> FRAC_BITS;
   end

   // shared saturating adder
   sum_type            sa_acc, sa_out;
   logic [63:0]        sa_mag;
   logic               sa_neg;
   logic signed [65:0] sa_wide, sa_ext, sa_add;
   always_comb begin
      case (state_ff)
         ST_POT: begin
            sa_acc = sum_pot_ff;
            sa_mag = dv_quo_ff;
            sa_neg = 1'b1;
         end
         ST_MASS: begin
            sa_acc = sum_mass_ff;
            sa_mag = 64'(body_ff.mass);
            sa_neg = 1'b0;
         end
         default: begin
            case (axis_ff)
               2'd0:    sa_acc = sum_x_ff;
               2'd1:    sa_acc = sum_y_ff;
               default: sa_acc = sum_z_ff;
            endcase
            sa_mag = (state_ff == ST_MSUM) ? axis_mag : '1;
            sa_neg = cur_neg;
         end
      endcase
      sa_ext  = 66'(sa_acc);
      sa_add  = $signed({2'b00, sa_mag});
      sa_wide = sa_neg ? sa_ext - sa_add : sa_ext + sa_add;
      if (sa_wide > SAT_HI)      sa_out = SUM_WIDTH'(SAT_HI);
      else if (sa_wide < SAT_LO) sa_out = SUM_WIDTH'(SAT_LO);
      else                       sa_out = SUM_WIDTH'(sa_wide);
   end

   assign body_ready = (state_ff == ST_IDLE);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         sum_pot_ff   <= '0;
         sum_mass_ff  <= '0;
      end else begin
         // result taken; the emit state reloads it itself
         if (rsp_valid_ff && rsp_ch.ready && state_ff != ST_EMIT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (body_valid) begin
                  body_ff  <= body_in;
                  state_ff <= (body_in.d2 == 64'd0) ? ST_MASS : ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               sh_ff     <= s_half;
               sq_rem_ff <= body_ff.d2 << s_amt;
               sq_res_ff <= '0;
               sq_bit_ff <= 64'd1 << 62;
               cnt_ff    <= 6'd31;
               state_ff  <= ST_SQRT;
            end
            ST_SQRT: begin
               sq_rem_ff <= sq_rem_nx;
               sq_res_ff <= sq_res_nx;
               sq_bit_ff <= sq_bit_ff >> 2;
               cnt_ff    <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  dv_num_ff <= 64'(body_ff.mass) << FRAC_BITS;
                  dv_den_ff <= root_dist;
                  dv_rem_ff <= '0;
                  dv_quo_ff <= '0;
                  cnt_ff    <= 6'd63;
                  state_ff  <= ST_DIVP;
               end
            end
            ST_DIVP, ST_DIVT: begin
               dv_rem_ff <= dv_rem_nx;
               dv_quo_ff <= dv_quo_nx;
               dv_num_ff <= dv_num_ff << 1;
               cnt_ff    <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd0) begin
                  if (state_ff == ST_DIVP) begin
                     state_ff <= ST_POT;
                  end else begin
                     t_ff     <= dv_quo_nx;
                     tinf_ff  <= 1'b0;
                     axis_ff  <= 2'd0;
                     state_ff <= ST_MLO;
                  end
               end
            end
            ST_POT: begin
               sum_pot_ff <= sa_out;
               if (dv_quo_ff[63:64-FRAC_BITS] != '0) begin
                  tinf_ff  <= 1'b1;
                  axis_ff  <= 2'd0;
                  state_ff <= ST_MLO;
               end else begin
                  dv_num_ff <= dv_quo_ff << FRAC_BITS;
                  dv_rem_ff <= '0;
                  dv_quo_ff <= '0;
                  cnt_ff    <= 6'd63;
                  state_ff  <= ST_DIVT;
               end
            end
            ST_MLO, ST_MSUM: begin
               if (state_ff == ST_MLO && cur_abs != 32'd0 && !tinf_ff) begin
                  pl_ff    <= mul_out;
                  state_ff <= ST_MHI;
               end else begin
                  // zero offset adds nothing on that axis
                  if (cur_abs != 32'd0) begin
                     case (axis_ff)
                        2'd0:    sum_x_ff <= sa_out;
                        2'd1:    sum_y_ff <= sa_out;
                        default: sum_z_ff <= sa_out;
                     endcase
                  end
                  if (axis_ff == 2'd2) begin
                     state_ff <= ST_MASS;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_MLO;
                  end
               end
            end
            ST_MHI: begin
               ph_ff    <= mul_out;
               state_ff <= ST_MSUM;
            end
            ST_MASS: begin
               sum_mass_ff <= sa_out;
               state_ff    <= body_ff.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  out_x_ff     <= out_bits(sum_x_ff);
                  out_y_ff     <= out_bits(sum_y_ff);
                  out_z_ff     <= out_bits(sum_z_ff);
                  out_pot_ff   <= out_bits(sum_pot_ff);
                  out_mass_ff  <= MASS_OUT_W'(out_bits(sum_mass_ff));
                  sum_x_ff     <= '0;
                  sum_y_ff     <= '0;
                  sum_z_ff     <= '0;
                  sum_pot_ff   <= '0;
                  sum_mass_ff  <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.accel_x    = out_x_ff;
   assign rsp_ch.accel_y    = out_y_ff;
   assign rsp_ch.accel_z    = out_z_ff;
   assign rsp_ch.potential  = out_pot_ff;
   assign rsp_ch.mass_total = out_mass_ff;

endmodule

// ===== src/sga_checker.sv =====
// ----------------------------------------------------------------------------
// sga_checker
// Port-level checks on the accumulator: result handshake and that every
// result item is owed to a last body accepted earlier.
// ----------------------------------------------------------------------------
module sga_checker import sga_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [MASS_OUT_W-1:0] rsp_mass
);

   logic [3:0] owed_ff;
   logic       last_in, rsp_out;

   assign last_in = req_valid && req_ready && req_last;
   assign rsp_out = rsp_valid && rsp_ready;

   // results still owed for accepted last bodies
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff <= '0;
      end else begin
         owed_ff <= owed_ff + {3'd0, last_in} - {3'd0, rsp_out};
      end
   end

   // a result held while stalled stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its mass total
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mass))
      else $error("result changed while stalled");

   // nothing shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // every result follows an accepted last body
   a_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> owed_ff != 4'd0)
      else $error("result without a closing body");

endmodule

bind softened_gravity_accumulator sga_checker u_sga_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.last_body),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_mass  (rsp_ch.mass_total)
);
